/* sv/ttgr_pkg.sv */
`timescale 1ns / 1ps

package ttgr_pkg;

    // Tracking mode of the single finger being followed
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_PRESSED  = 2'd1,
        MODE_RELEASED = 2'd2,
        MODE_PRESSED2 = 2'd3
    } mode_t;

    // Reported gesture kind
    typedef enum logic [1:0] {
        GEST_TAP      = 2'd0,
        GEST_LONG     = 2'd1,
        GEST_DOUBLE   = 2'd2,
        GEST_TAP_LONG = 2'd3
    } gesture_t;

    // Input item kind carried on tuser
    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_HOLD_INTERVAL = 2'd0;
    localparam logic [1:0] REG_TAP_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_MOVE_TOL      = 2'd2;

    localparam int unsigned POS_W   = 12;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned FID_W   = 4;

    localparam logic [TIMER_W-1:0] HOLD_RESET = 16'd500;
    localparam logic [TIMER_W-1:0] TAP_RESET  = 16'd300;
    localparam logic [POS_W-1:0]   TOL_RESET  = 12'd20;
    localparam logic [TIMER_W-1:0] TIMER_MAX  = 16'hFFFF;

    // Unpacked view of one input transaction
    typedef struct packed {
        logic              op;
        logic              multi_touch;
        logic [FID_W-1:0]  finger_id;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic              is_pressed;
        logic              is_released;
    } item_t;

endpackage

/* sv/touch_tap_gesture_recognizer.sv */
`timescale 1ns / 1ps

// Single-finger tap gesture recognizer.
//
// Input stream (s_axis_*): one transaction is either a touch report or a
// one-millisecond tick, selected by s_axis_tuser. Ticks drive a one-shot
// timer; reports drive the idle / pressed / released / pressed-again tracker.
// Output stream (m_axis_*): at most one gesture per input transaction:
// tap, long tap, double tap or tap-then-long-tap, with the start position.
// Config port: cfg_wr_en / cfg_index / cfg_wdata write hold interval (0),
// tap interval (1) and move tolerance (2); other indexes are ignored.
// Write configuration only while no transaction is in flight.
//
// Path: an accepted transaction lands in the input register, is
// evaluated against the tracker state once the output register has room,
// and its gesture (if any) is registered into the output register for m_axis.
// Throughput: one transaction per cycle while m_axis_tready stays high;
// the whole state update is one combinational pass between the input and
// output registers.
// Stall: while the output register holds an untaken gesture, the input
// register keeps its item and s_axis_tready drops once both are full.
// Reset: tracker goes idle, timer stops, registers return to 500 / 300 / 20.
module touch_tap_gesture_recognizer (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: multi_touch[0], finger_id[4:1], pos_x[16:5], pos_y[28:17],
    //        is_pressed[29], is_released[30], zero pad[31]
    input  logic [31:0] s_axis_tdata,
    // tuser: operation[0] (0 touch report, 1 tick)
    input  logic        s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: gesture_x[11:0], gesture_y[23:12]
    output logic [23:0] m_axis_tdata,
    // tuser: gesture[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int unsigned PW = ttgr_pkg::POS_W;
    localparam int unsigned TW = ttgr_pkg::TIMER_W;
    localparam int unsigned FW = ttgr_pkg::FID_W;

    // Configuration registers
    logic [TW-1:0] hold_interval_reg;
    logic [TW-1:0] tap_interval_reg;
    logic [PW-1:0] move_tol_reg;

    // Input register
    logic             in_valid_reg;
    ttgr_pkg::item_t  in_item_reg;

    // Tracker state
    ttgr_pkg::mode_t  mode_reg, mode_next;
    logic [FW-1:0]    start_finger_reg, start_finger_next;
    logic [PW-1:0]    start_x_reg, start_x_next;
    logic [PW-1:0]    start_y_reg, start_y_next;
    logic             timer_run_reg, timer_run_next;
    logic [TW-1:0]    timer_count_reg, timer_count_next;
    logic             timer_tap_reg, timer_tap_next;

    // Output register
    logic               out_valid_reg;
    ttgr_pkg::gesture_t out_gesture_reg;
    logic [PW-1:0]      out_x_reg;
    logic [PW-1:0]      out_y_reg;

    logic               advance;
    logic               res_valid;
    ttgr_pkg::gesture_t res_gesture;

    logic [PW-1:0] dx, dy, dmax;
    logic          moved;
    logic          finger_diff;
    logic          abandon;
    logic [TW-1:0] count_inc;
    logic [TW-1:0] limit;
    logic          fire;
    logic          is_tick;

    // Evaluate the held item when the output register has room for its result
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_interval_reg <= ttgr_pkg::HOLD_RESET;
            tap_interval_reg  <= ttgr_pkg::TAP_RESET;
            move_tol_reg      <= ttgr_pkg::TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ttgr_pkg::REG_HOLD_INTERVAL: hold_interval_reg <= cfg_wdata;
                ttgr_pkg::REG_TAP_INTERVAL:  tap_interval_reg  <= cfg_wdata;
                ttgr_pkg::REG_MOVE_TOL:      move_tol_reg      <= cfg_wdata[PW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.op          <= s_axis_tuser;
            in_item_reg.multi_touch <= s_axis_tdata[0];
            in_item_reg.finger_id   <= s_axis_tdata[4:1];
            in_item_reg.pos_x       <= s_axis_tdata[16:5];
            in_item_reg.pos_y       <= s_axis_tdata[28:17];
            in_item_reg.is_pressed  <= s_axis_tdata[29];
            in_item_reg.is_released <= s_axis_tdata[30];
        end
    end

    // ---------------- shared datapath ----------------
    // Chebyshev distance from the start point
    assign dx   = (in_item_reg.pos_x > start_x_reg) ? (in_item_reg.pos_x - start_x_reg)
                                                    : (start_x_reg - in_item_reg.pos_x);
    assign dy   = (in_item_reg.pos_y > start_y_reg) ? (in_item_reg.pos_y - start_y_reg)
                                                    : (start_y_reg - in_item_reg.pos_y);
    assign dmax  = (dx > dy) ? dx : dy;
    assign moved = dmax > move_tol_reg;
    assign finger_diff = in_item_reg.finger_id != start_finger_reg;

    assign abandon = (((mode_reg == ttgr_pkg::MODE_PRESSED) ||
                       (mode_reg == ttgr_pkg::MODE_PRESSED2)) && (finger_diff || moved)) ||
                     ((mode_reg == ttgr_pkg::MODE_RELEASED) && moved);

    // Saturating timer step and expiry
    assign count_inc = (timer_count_reg == ttgr_pkg::TIMER_MAX) ? timer_count_reg
                                                                : timer_count_reg + 1'b1;
    assign limit   = timer_tap_reg ? tap_interval_reg : hold_interval_reg;
    assign fire    = timer_run_reg && (count_inc >= limit);
    assign is_tick = in_item_reg.op == ttgr_pkg::OP_TICK;

    // ---------------- next state ----------------
    always_comb
    begin
        mode_next         = mode_reg;
        start_finger_next = start_finger_reg;
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        timer_run_next    = timer_run_reg;
        timer_count_next  = timer_count_reg;
        timer_tap_next    = timer_tap_reg;

        if (advance)
        begin
            if (is_tick)
            begin
                if (timer_run_reg)
                begin
                    timer_count_next = count_inc;
                    if (fire)
                    begin
                        timer_run_next = 1'b0;
                        mode_next      = ttgr_pkg::MODE_IDLE;
                    end
                end
            end
            else if (in_item_reg.multi_touch || abandon)
            begin
                mode_next      = ttgr_pkg::MODE_IDLE;
                timer_run_next = 1'b0;
            end
            else if (in_item_reg.is_pressed || in_item_reg.is_released)
            begin
                // any meaningful flag cancels a pending timeout
                timer_run_next = 1'b0;
                unique case (mode_reg)
                    ttgr_pkg::MODE_IDLE,
                    ttgr_pkg::MODE_RELEASED:
                    begin
                        if (in_item_reg.is_pressed)
                        begin
                            start_finger_next = in_item_reg.finger_id;
                            start_x_next      = in_item_reg.pos_x;
                            start_y_next      = in_item_reg.pos_y;
                            mode_next         = (mode_reg == ttgr_pkg::MODE_IDLE)
                                                ? ttgr_pkg::MODE_PRESSED
                                                : ttgr_pkg::MODE_PRESSED2;
                            timer_run_next    = 1'b1;
                            timer_count_next  = '0;
                            timer_tap_next    = 1'b0;
                        end
                    end
                    ttgr_pkg::MODE_PRESSED:
                    begin
                        if (in_item_reg.is_released)
                        begin
                            mode_next        = ttgr_pkg::MODE_RELEASED;
                            timer_run_next   = 1'b1;
                            timer_count_next = '0;
                            timer_tap_next   = 1'b1;
                        end
                    end
                    ttgr_pkg::MODE_PRESSED2:
                    begin
                        if (in_item_reg.is_released)
                            mode_next = ttgr_pkg::MODE_IDLE;
                    end
                    default: ;
                endcase
            end
        end
    end

    // ---------------- result ----------------
    always_comb
    begin
        res_valid   = 1'b0;
        res_gesture = ttgr_pkg::GEST_TAP;
        if (is_tick)
        begin
            if (fire)
            begin
                unique case (mode_reg)
                    ttgr_pkg::MODE_PRESSED:
                    begin
                        res_valid   = 1'b1;
                        res_gesture = ttgr_pkg::GEST_LONG;
                    end
                    ttgr_pkg::MODE_RELEASED:
                    begin
                        res_valid   = 1'b1;
                        res_gesture = ttgr_pkg::GEST_TAP;
                    end
                    ttgr_pkg::MODE_PRESSED2:
                    begin
                        res_valid   = 1'b1;
                        res_gesture = ttgr_pkg::GEST_TAP_LONG;
                    end
                    default: ;
                endcase
            end
        end
        else if (!in_item_reg.multi_touch && !abandon && in_item_reg.is_released &&
                 (mode_reg == ttgr_pkg::MODE_PRESSED2))
        begin
            res_valid   = 1'b1;
            res_gesture = ttgr_pkg::GEST_DOUBLE;
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= ttgr_pkg::MODE_IDLE;
            start_finger_reg <= '0;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            timer_run_reg    <= 1'b0;
            timer_count_reg  <= '0;
            timer_tap_reg    <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            start_finger_reg <= start_finger_next;
            start_x_reg      <= start_x_next;
            start_y_reg      <= start_y_next;
            timer_run_reg    <= timer_run_next;
            timer_count_reg  <= timer_count_next;
            timer_tap_reg    <= timer_tap_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_gesture_reg <= res_gesture;
            out_x_reg       <= start_x_reg;
            out_y_reg       <= start_y_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_gesture_reg;
    assign m_axis_tdata  = {out_y_reg, out_x_reg};

endmodule

/* verif/ttgr_checker.sv */
`timescale 1ns / 1ps

module ttgr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          mismatches,
    output int          pending
);
    import ttgr_pkg::*;

    typedef struct packed {
        gesture_t         kind;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } gesture_rec_t;

    gesture_rec_t expected_gestures[$];

    // shadow tracker
    mode_t              trk_mode;
    logic [FID_W-1:0]   trk_finger;
    logic [POS_W-1:0]   trk_x;
    logic [POS_W-1:0]   trk_y;
    logic               tmr_on;
    logic [TIMER_W-1:0] tmr_count;
    logic               tmr_tap;

    // shadow registers
    logic [TIMER_W-1:0] cfg_hold;
    logic [TIMER_W-1:0] cfg_tap;
    logic [POS_W-1:0]   cfg_tol;

    task automatic report(input string msg);
        $display("[%0t] gesture check: %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit beyond_tolerance(input logic [POS_W-1:0] x,
                                            input logic [POS_W-1:0] y);
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
        dx = (x > trk_x) ? x - trk_x : trk_x - x;
        dy = (y > trk_y) ? y - trk_y : trk_y - y;
        return ((dx > dy) ? dx : dy) > cfg_tol;
    endfunction

    task automatic arm_timer(input logic use_tap);
        tmr_on    = 1'b1;
        tmr_count = '0;
        tmr_tap   = use_tap;
    endtask

    // advance the shadow tracker by one transaction
    task automatic track_gesture(input logic op, input logic [31:0] d,
                                 output bit hit, output gesture_rec_t rec);
        logic               multi;
        logic [FID_W-1:0]   fid;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic               prs;
        logic               rls;
        logic [TIMER_W-1:0] limit;
        mode_t              was;
        multi = d[0];
        fid   = d[4:1];
        px    = d[16:5];
        py    = d[28:17];
        prs   = d[29];
        rls   = d[30];
        hit   = 1'b0;
        rec   = '0;
        if (op == OP_TICK) begin
            if (tmr_on) begin
                if (tmr_count != TIMER_MAX)
                    tmr_count = tmr_count + 1'b1;
                limit = tmr_tap ? cfg_tap : cfg_hold;
                if (tmr_count >= limit) begin
                    was      = trk_mode;
                    trk_mode = MODE_IDLE;
                    tmr_on   = 1'b0;
                    rec.x    = trk_x;
                    rec.y    = trk_y;
                    hit      = (was != MODE_IDLE);
                    case (was)
                        MODE_PRESSED:  rec.kind = GEST_LONG;
                        MODE_RELEASED: rec.kind = GEST_TAP;
                        default:       rec.kind = GEST_TAP_LONG;
                    endcase
                end
            end
        end else if (multi) begin
            trk_mode = MODE_IDLE;
            tmr_on   = 1'b0;
        end else if ((trk_mode == MODE_PRESSED || trk_mode == MODE_PRESSED2) &&
                     (fid != trk_finger || beyond_tolerance(px, py))) begin
            trk_mode = MODE_IDLE;
            tmr_on   = 1'b0;
        end else if (trk_mode == MODE_RELEASED && beyond_tolerance(px, py)) begin
            trk_mode = MODE_IDLE;
            tmr_on   = 1'b0;
        end else if (prs || rls) begin
            // any flag stops the timer, even one that moves nothing
            tmr_on = 1'b0;
            case (trk_mode)
                MODE_IDLE: begin
                    if (prs) begin
                        trk_finger = fid;
                        trk_x      = px;
                        trk_y      = py;
                        trk_mode   = MODE_PRESSED;
                        arm_timer(1'b0);
                    end
                end
                MODE_PRESSED: begin
                    if (rls) begin
                        trk_mode = MODE_RELEASED;
                        arm_timer(1'b1);
                    end
                end
                MODE_RELEASED: begin
                    if (prs) begin
                        trk_finger = fid;
                        trk_x      = px;
                        trk_y      = py;
                        trk_mode   = MODE_PRESSED2;
                        arm_timer(1'b0);
                    end
                end
                default: begin
                    if (rls) begin
                        trk_mode = MODE_IDLE;
                        hit      = 1'b1;
                        rec.kind = GEST_DOUBLE;
                        rec.x    = trk_x;
                        rec.y    = trk_y;
                    end
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        bit           hit;
        gesture_rec_t rec;
        gesture_rec_t want;
        gesture_t     got_kind;
        if (!rst_n) begin
            trk_mode   = MODE_IDLE;
            trk_finger = '0;
            trk_x      = '0;
            trk_y      = '0;
            tmr_on     = 1'b0;
            tmr_count  = '0;
            tmr_tap    = 1'b0;
            cfg_hold   = HOLD_RESET;
            cfg_tap    = TAP_RESET;
            cfg_tol    = TOL_RESET;
            expected_gestures.delete();
            mismatches = 0;
            pending    = 0;
        end else begin
            // outputs are older than anything accepted at this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got_kind = gesture_t'(m_axis_tuser);
                if (expected_gestures.size() == 0) begin
                    report($sformatf("unexpected gesture %s at (%0d,%0d)",
                                     got_kind.name(), m_axis_tdata[11:0],
                                     m_axis_tdata[23:12]));
                end else begin
                    want = expected_gestures.pop_front();
                    if (got_kind != want.kind)
                        report($sformatf("gesture %s, wanted %s",
                                         got_kind.name(), want.kind.name()));
                    if (m_axis_tdata[11:0] != want.x)
                        report($sformatf("gesture_x %0d, wanted %0d",
                                         m_axis_tdata[11:0], want.x));
                    if (m_axis_tdata[23:12] != want.y)
                        report($sformatf("gesture_y %0d, wanted %0d",
                                         m_axis_tdata[23:12], want.y));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HOLD_INTERVAL: cfg_hold = cfg_wdata;
                    REG_TAP_INTERVAL:  cfg_tap  = cfg_wdata;
                    REG_MOVE_TOL:      cfg_tol  = cfg_wdata[POS_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                track_gesture(s_axis_tuser, s_axis_tdata, hit, rec);
                if (hit)
                    expected_gestures.push_back(rec);
            end
            pending = expected_gestures.size();
        end
    end

endmodule

/* verif/touch_tap_gesture_recognizer_test.sv */
`timescale 1ns / 1ps

module touch_tap_gesture_recognizer_test;
    import ttgr_pkg::*;

    // index with no register behind it; writes must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;
    // cycles to let an in-flight transaction drain (input and output register + margin)
    localparam int SETTLE_CYCLES = 8;
    // receiver hold-off used to back the block up
    localparam int HOLD_OFF_CYCLES = 60;

    logic        clk = 1'b0;
    logic        rst_n;
    logic [31:0] s_axis_tdata;   // multi_touch, finger_id, pos_x, pos_y, pressed, released
    logic        s_axis_tuser;   // operation
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] m_axis_tdata;   // gesture_x, gesture_y
    logic [1:0]  m_axis_tuser;   // gesture
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    int mismatches;
    int pending;

    // idling knobs, read by the sender task and the receiver process
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_seq     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    // register values last written, to size the random gestures
    int cur_hold = int'(HOLD_RESET);
    int cur_tap  = int'(TAP_RESET);
    int cur_tol  = int'(TOL_RESET);

    int items_sent = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    touch_tap_gesture_recognizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    ttgr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Receiver: random stalls per stall_pct; a bump of hold_seq starts a
    // long hold-off counted here so the block fills and drops s_axis_tready.
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Run limit: a watchdog that ends the run with a mismatch verdict if it has not finished
    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [31:0] touch_word(input logic multi, input logic [3:0] fid,
                                               input logic [11:0] x, input logic [11:0] y,
                                               input logic prs, input logic rls);
        return {1'b0, rls, prs, y, x, fid, multi};
    endfunction

    // Offer one transaction; returns at the falling edge after acceptance
    // with tvalid still high, so back-to-back items keep tvalid up.
    task automatic send_item(input logic op, input logic [31:0] data);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic touch(input logic multi, input logic [3:0] fid, input logic [11:0] x,
                         input logic [11:0] y, input logic prs, input logic rls);
        send_item(OP_TOUCH, touch_word(multi, fid, x, y, prs, rls));
    endtask

    // tick fields are don't-care; randomize them anyway
    task automatic ticks(input int n);
        repeat (n) send_item(OP_TICK, $urandom());
    endtask

    // drop tvalid, drain expected gestures, then let no-result items retire
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // wr_en is raised and lowered at separate falling edges so wr_en never gets two updates in one step
    task automatic write_reg(input logic [1:0] idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[15:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_HOLD_INTERVAL: cur_hold = val;
            REG_TAP_INTERVAL:  cur_tap  = val;
            REG_MOVE_TOL:      cur_tol  = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input int hold, input int tap, input int tol);
        settle();
        write_reg(REG_HOLD_INTERVAL, hold);
        write_reg(REG_TAP_INTERVAL, tap);
        write_reg(REG_MOVE_TOL, tol);
    endtask

    function automatic int pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 1;
        if (r < 20) return 65535;
        return $urandom_range(2, 24);
    endfunction

    function automatic int pick_tol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 25) return 4095;
        return $urandom_range(1, 40);
    endfunction

    // position near c: mostly inside tolerance, sometimes just past it
    function automatic int near(input int c);
        int span;
        int off;
        int v;
        span = (cur_tol > 60) ? 60 : cur_tol;
        if ($urandom_range(0, 9) == 0)
            off = $urandom_range(0, 2 * span + 4) - (span + 2);
        else
            off = $urandom_range(0, 2 * span) - span;
        v = c + off;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    // enough ticks to sometimes reach the interval, capped for long ones
    function automatic int reach(input int iv);
        return (iv + 1 > 40) ? 40 : iv + 1;
    endfunction

    task automatic noise_item();
        touch(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // time passing while the finger rests: ticks, jitter reports, rare noise
    task automatic dwell(input logic [3:0] fid, input int x, input int y, input int lim);
        int n;
        n = $urandom_range(0, lim);
        repeat (n)
        begin
            case ($urandom_range(0, 15))
                0: touch(1'b0, fid, 12'(near(x)), 12'(near(y)), 1'b0, 1'b0);
                1:
                begin
                    if ($urandom_range(0, 3) == 0)
                        noise_item();
                    else
                        ticks(1);
                end
                default: ticks(1);
            endcase
        end
    endtask

    // one mostly well-formed press / release / press-again sequence
    task automatic make_gesture();
        logic [3:0] fid;
        logic [3:0] fid2;
        int x;
        int y;
        fid  = 4'($urandom_range(0, 15));
        fid2 = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : fid;
        x    = $urandom_range(0, 4095);
        y    = $urandom_range(0, 4095);
        if ($urandom_range(0, 9) == 0)
            noise_item();
        touch(1'b0, fid, 12'(x), 12'(y), 1'b1, $urandom_range(0, 9) == 0);
        dwell(fid, x, y, reach(cur_hold));
        if ($urandom_range(0, 99) < 85)
        begin
            touch(1'b0, fid, 12'(near(x)), 12'(near(y)), $urandom_range(0, 9) == 0, 1'b1);
            dwell(fid, x, y, reach(cur_tap));
            if ($urandom_range(0, 99) < 60)
            begin
                x = near(x);
                y = near(y);
                touch(1'b0, fid2, 12'(x), 12'(y), 1'b1, 1'b0);
                dwell(fid2, x, y, reach(cur_hold));
                if ($urandom_range(0, 99) < 70)
                    touch(1'b0, fid2, 12'(near(x)), 12'(near(y)), 1'b0, 1'b1);
            end
        end
    endtask

    initial
    begin
        int gap_tbl[4];
        int stall_tbl[4];
        int target;
        int w;
        gap_tbl   = '{0, 50, 0, 12};
        stall_tbl = '{0, 0, 50, 12};

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = OP_TOUCH;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_HOLD_INTERVAL;
        cfg_wdata     = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed: short intervals so every timeout is reachable ----
        set_config(2, 2, 5);
        ticks(1);                                           // stopped timer: nothing
        touch(1'b0, 4'd15, 12'd4095, 12'd4095, 1'b1, 1'b0);
        ticks(2);                                           // long tap at max corner
        touch(1'b0, 4'd0, 12'd0, 12'd0, 1'b1, 1'b0);
        touch(1'b0, 4'd0, 12'd0, 12'd0, 1'b0, 1'b1);
        ticks(2);                                           // tap at origin
        touch(1'b0, 4'd3, 12'd100, 12'd200, 1'b1, 1'b0);
        touch(1'b0, 4'd3, 12'd103, 12'd200, 1'b0, 1'b1);
        touch(1'b0, 4'd3, 12'd105, 12'd198, 1'b1, 1'b0);    // start moves on 2nd press
        touch(1'b0, 4'd3, 12'd105, 12'd198, 1'b0, 1'b1);    // double tap
        touch(1'b0, 4'd7, 12'd2048, 12'd1024, 1'b1, 1'b1);  // both flags: press wins in idle
        touch(1'b0, 4'd7, 12'd2048, 12'd1024, 1'b1, 1'b1);  // release wins in pressed
        touch(1'b0, 4'd7, 12'd2048, 12'd1024, 1'b1, 1'b0);
        ticks(2);                                           // tap then long tap
        touch(1'b0, 4'd1, 12'd10, 12'd10, 1'b1, 1'b0);
        touch(1'b1, 4'd1, 12'd10, 12'd10, 1'b0, 1'b0);      // multi-touch aborts
        touch(1'b0, 4'd1, 12'd10, 12'd10, 1'b1, 1'b0);
        touch(1'b0, 4'd2, 12'd10, 12'd10, 1'b0, 1'b0);      // other finger aborts
        touch(1'b0, 4'd1, 12'd10, 12'd10, 1'b1, 1'b0);
        touch(1'b0, 4'd1, 12'd16, 12'd10, 1'b0, 1'b0);      // moved past tolerance
        touch(1'b0, 4'd1, 12'd10, 12'd10, 1'b1, 1'b0);
        touch(1'b0, 4'd1, 12'd10, 12'd10, 1'b0, 1'b1);
        touch(1'b0, 4'd1, 12'd10, 12'd4, 1'b0, 1'b0);       // moved while released
        touch(1'b0, 4'd4, 12'd50, 12'd50, 1'b1, 1'b0);
        touch(1'b0, 4'd4, 12'd50, 12'd50, 1'b1, 1'b0);      // repeated press kills timer
        ticks(3);
        touch(1'b0, 4'd4, 12'd50, 12'd50, 1'b0, 1'b1);
        ticks(2);                                           // tap

        // unknown index dropped; then lower hold below the running count
        settle();
        write_reg(REG_UNUSED, 1);
        write_reg(REG_HOLD_INTERVAL, 100);
        touch(1'b0, 4'd9, 12'd300, 12'd300, 1'b1, 1'b0);
        ticks(5);
        settle();
        write_reg(REG_HOLD_INTERVAL, 3);
        ticks(1);                                           // fires at once
        // zero interval: first tick fires
        settle();
        write_reg(REG_HOLD_INTERVAL, 0);
        touch(1'b0, 4'd9, 12'd301, 12'd302, 1'b1, 1'b0);
        ticks(1);

        // ---- random: four idling phases, two register settings each ----
        for (int p = 0; p < 4; p++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                if (p == 0 && s == 0)
                    set_config(1, 1, 0);
                else if (p == 1 && s == 0)
                    set_config(24, 65535, 4095);
                else
                    set_config(pick_interval(), pick_interval(), pick_tol());
                send_gap_pct = gap_tbl[p];
                stall_pct    = stall_tbl[p];
                target = items_sent + 60;
                while (items_sent < target)
                    make_gesture();
            end
        end

        // ---- back-pressure: receiver holds off while press/tick pairs
        //      each make a long tap, so the block fills and stalls input ----
        send_gap_pct = 0;
        stall_pct    = 0;
        set_config(1, 1, 10);
        hold_seq++;
        repeat (12)
        begin
            touch(1'b0, 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), 1'b1, 1'b0);
            ticks(1);
        end

        // ---- drain and verdict ----
        s_axis_tvalid <= 1'b0;
        for (w = 0; w < 5000 && pending != 0; w++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
sv/ttgr_pkg.sv
sv/touch_tap_gesture_recognizer.sv
verif/ttgr_checker.sv
verif/touch_tap_gesture_recognizer_test.sv
